### rtl/core/lsma_pkg.sv
// ----------------------------------------------------------------------------
// lsma_pkg
// shared widths, microcode encoding and control program of the light
// sample moving average core
// ----------------------------------------------------------------------------
package lsma_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int LEVEL_W      = 10;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W        = LEVEL_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int FRAC_W       = 6;
    localparam int AVG_W        = 16;
    localparam int DVD_W        = SUM_W + FRAC_W;
    localparam int DCNT_W       = $clog2(DVD_W + 1);
    localparam int PC_W         = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1023);

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_TAKE,
        OP_WRITE,
        OP_READ,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TRACK,
        OP_EMIT
    } op_t;

    // jump condition of one microcode step
    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_SCAN_MORE,
        COND_EMPTY,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // status from the datapath that the sequencer branches on
    typedef struct packed {
        logic no_input;
        logic scan_more;
        logic empty;
        logic div_busy;
        logic out_busy;
    } flags_t;

    localparam logic [PC_W-1:0] STEP_TAKE     = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_WRITE    = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_READ     = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_ACC      = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_DIV_INIT = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_DIV_STEP = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_TRACK    = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_EMIT     = PC_W'(7);

    // control program; the step after the last one wraps to the first
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_TAKE, cond: COND_NO_INPUT, target: STEP_TAKE};
        unique case (pc)
            STEP_TAKE:     w = '{op: OP_TAKE,     cond: COND_NO_INPUT,  target: STEP_TAKE};
            STEP_WRITE:    w = '{op: OP_WRITE,    cond: COND_NONE,      target: STEP_TAKE};
            STEP_READ:     w = '{op: OP_READ,     cond: COND_NONE,      target: STEP_TAKE};
            STEP_ACC:      w = '{op: OP_ACC,      cond: COND_SCAN_MORE, target: STEP_ACC};
            STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_EMPTY,     target: STEP_TRACK};
            STEP_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY,  target: STEP_DIV_STEP};
            STEP_TRACK:    w = '{op: OP_TRACK,    cond: COND_NONE,      target: STEP_TAKE};
            STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY,  target: STEP_EMIT};
            default:       w = '{op: OP_TAKE,     cond: COND_NO_INPUT,  target: STEP_TAKE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/light_sample_moving_average_core.sv
// ----------------------------------------------------------------------------
// light_sample_moving_average_core
// moving average of 10-bit light samples over a circular window, with
// running min/max of the average (smoothed) or of the sample (raw)
// ----------------------------------------------------------------------------
//
//  channel   direction  ports                                   carries
//  s_        in         s_valid s_ready s_mode s_sample         one sample beat
//  m_        out        m_valid m_ready m_average m_level       one result beat
//                       m_max_level m_min_level m_window_empty
//  cfg_      in         cfg_valid cfg_ready cfg_wdata           invert register
//
//  one item is handled at a time; n is the number of window slots scanned
//  (leading non-empty slots plus the slot that ends the run, at most 16);
//  the restoring divide has 20 steps and drops out for an empty window;
//  the window scan and divide loop set how long an item takes
//  reset: synchronous active low aresetn; window slots read as empty through
//  per-slot valid bits, min level 1023, max level 0, invert off
//  a stalled result holds in the output register; the sequencer waits at its
//  emit step only when a second result would overwrite one not yet taken
//  s_ready and cfg_ready stay low while aresetn is low; out of reset config
//  writes are accepted in every cycle
//
module light_sample_moving_average_core
    import lsma_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // sample input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [LEVEL_W-1:0] s_sample,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [AVG_W-1:0]   m_average,
    output logic [LEVEL_W-1:0] m_level,
    output logic [LEVEL_W-1:0] m_max_level,
    output logic [LEVEL_W-1:0] m_min_level,
    output logic               m_window_empty,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_wdata
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

    // sequencer
    uword_t uword;
    flags_t flags;

    // window storage
    logic [LEVEL_W-1:0]      window_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] slot_valid_reg;
    logic [LEVEL_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;

    // control and working registers
    logic               invert_reg,     invert_next;
    logic [IDX_W-1:0]   wslot_reg,      wslot_next;
    logic [IDX_W-1:0]   idx_reg,        idx_next;
    logic               mode_reg,       mode_next;
    logic [LEVEL_W-1:0] level_reg,      level_next;
    logic [SUM_W-1:0]   sum_reg,        sum_next;
    logic [CNT_W-1:0]   cnt_reg,        cnt_next;
    logic [DVD_W-1:0]   dvd_reg,        dvd_next;
    logic [CNT_W-1:0]   rem_reg,        rem_next;
    logic [DCNT_W-1:0]  dcnt_reg,       dcnt_next;
    logic [LEVEL_W-1:0] hi_reg,         hi_next;
    logic [LEVEL_W-1:0] lo_reg,         lo_next;

    // output register
    logic               m_valid_reg,    m_valid_next;
    logic [AVG_W-1:0]   m_average_reg,  m_average_next;
    logic [LEVEL_W-1:0] m_level_reg,    m_level_next;
    logic [LEVEL_W-1:0] m_max_reg,      m_max_next;
    logic [LEVEL_W-1:0] m_min_reg,      m_min_next;
    logic               m_empty_reg,    m_empty_next;

    logic               rd_nonzero;
    logic               empty;
    logic [CNT_W:0]     trial;
    logic               qbit;
    logic [LEVEL_W-1:0] track_val;
    logic               track_en;
    logic               emit_fire;

    lsma_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    // no beat is taken while reset holds
    assign s_ready   = aresetn && (uword.op == OP_TAKE);
    assign cfg_ready = aresetn;

    assign rd_nonzero = (rd_data_reg != '0);
    assign empty      = (cnt_reg == '0);

    // one restoring divide step: shift in the next dividend bit, try subtract
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit  = (trial >= {1'b0, cnt_reg});

    // raw mode tracks the stored sample, smoothed mode the integer average
    assign track_val = mode_reg ? level_reg : dvd_reg[FRAC_W +: LEVEL_W];
    assign track_en  = mode_reg || !empty;

    assign emit_fire = (uword.op == OP_EMIT) && !flags.out_busy;

    always_comb begin
        flags.no_input  = !s_valid;
        flags.scan_more = rd_nonzero && (idx_reg != IDX_LAST);
        flags.empty     = empty;
        flags.div_busy  = (dcnt_reg != DCNT_W'(1));
        flags.out_busy  = m_valid_reg && !m_ready;
    end

    // read address: slot 0 at the start of a scan, then one ahead of idx
    always_comb begin
        rd_addr = '0;
        if (uword.op == OP_ACC && idx_reg != IDX_LAST) begin
            rd_addr = idx_reg + 1'b1;
        end
    end

    always_comb begin
        invert_next    = invert_reg;
        wslot_next     = wslot_reg;
        idx_next       = idx_reg;
        mode_next      = mode_reg;
        level_next     = level_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        m_average_next = m_average_reg;
        m_level_next   = m_level_reg;
        m_max_next     = m_max_reg;
        m_min_next     = m_min_reg;
        m_empty_next   = m_empty_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cfg_valid && cfg_ready) begin
            invert_next = cfg_wdata;
        end

        unique case (uword.op)
            OP_TAKE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    level_next = invert_reg ? LEVEL_FULL - s_sample : s_sample;
                end
            end
            OP_WRITE: begin
                wslot_next = (wslot_reg == IDX_LAST) ? '0 : wslot_reg + 1'b1;
                sum_next   = '0;
                cnt_next   = '0;
            end
            OP_READ: begin
                idx_next = '0;
            end
            OP_ACC: begin
                if (rd_nonzero) begin
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_DIV_INIT: begin
                dvd_next  = {sum_reg, {FRAC_W{1'b0}}};
                rem_next  = '0;
                dcnt_next = DCNT_W'(DVD_W);
            end
            OP_DIV_STEP: begin
                rem_next  = qbit ? CNT_W'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], qbit};
                dcnt_next = dcnt_reg - 1'b1;
            end
            OP_TRACK: begin
                if (track_en) begin
                    if (track_val > hi_reg) begin
                        hi_next = track_val;
                    end
                    if (track_val < lo_reg) begin
                        lo_next = track_val;
                    end
                end
            end
            OP_EMIT: begin
                if (emit_fire) begin
                    m_valid_next   = 1'b1;
                    m_average_next = empty ? '0 : dvd_reg[AVG_W-1:0];
                    m_level_next   = level_reg;
                    m_max_next     = hi_reg;
                    m_min_next     = lo_reg;
                    m_empty_next   = empty;
                end
            end
            default: begin
            end
        endcase
    end

    // window memory with registered read; a slot never written reads empty
    always_ff @(posedge aclk) begin
        if (uword.op == OP_WRITE) begin
            window_mem[wslot_reg] <= level_reg;
        end
        rd_data_reg <= slot_valid_reg[rd_addr] ? window_mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            invert_reg     <= 1'b0;
            wslot_reg      <= '0;
            hi_reg         <= '0;
            lo_reg         <= LEVEL_FULL;
            m_valid_reg    <= 1'b0;
        end else begin
            if (uword.op == OP_WRITE) begin
                slot_valid_reg[wslot_reg] <= 1'b1;
            end
            invert_reg  <= invert_next;
            wslot_reg   <= wslot_next;
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        mode_reg      <= mode_next;
        level_reg     <= level_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        dcnt_reg      <= dcnt_next;
        m_average_reg <= m_average_next;
        m_level_reg   <= m_level_next;
        m_max_reg     <= m_max_next;
        m_min_reg     <= m_min_next;
        m_empty_reg   <= m_empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_average      = m_average_reg;
    assign m_level        = m_level_reg;
    assign m_max_level    = m_max_reg;
    assign m_min_level    = m_min_reg;
    assign m_window_empty = m_empty_reg;

endmodule

### rtl/core/lsma_seq.sv
// ----------------------------------------------------------------------------
// lsma_seq
// step counter and program table; jumps on datapath status flags
// ----------------------------------------------------------------------------
module lsma_seq
    import lsma_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output uword_t uword
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign uword = ucode(pc_reg);

    always_comb begin
        unique case (uword.cond)
            COND_NONE:      jump = 1'b0;
            COND_NO_INPUT:  jump = flags.no_input;
            COND_SCAN_MORE: jump = flags.scan_more;
            COND_EMPTY:     jump = flags.empty;
            COND_DIV_BUSY:  jump = flags.div_busy;
            COND_OUT_BUSY:  jump = flags.out_busy;
            default:        jump = 1'b0;
        endcase
        pc_next = jump ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_TAKE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/core/lsma_checker.sv
// ----------------------------------------------------------------------------
// lsma_checker
// port-level checks of the light sample moving average core
// ----------------------------------------------------------------------------
module lsma_checker
    import lsma_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [AVG_W-1:0]   m_average,
    input logic [LEVEL_W-1:0] m_max_level,
    input logic [LEVEL_W-1:0] m_min_level,
    input logic               m_window_empty
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average))
        else $error("result beat changed while stalled");

    // one item at a time: no second accept in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while item in progress");

    // empty window forces a zero average
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_empty |-> m_average == '0)
        else $error("nonzero average on empty window");

    // a non-empty window averages nonzero slots, so at least one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_empty |-> m_average >= AVG_W'(64))
        else $error("average below one on non-empty window");

    // a tracked value was seen, so min does not exceed max
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_empty |-> m_min_level <= m_max_level)
        else $error("min level above max level");

endmodule

bind light_sample_moving_average_core lsma_checker u_lsma_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_average      (m_average),
    .m_max_level    (m_max_level),
    .m_min_level    (m_min_level),
    .m_window_empty (m_window_empty)
);
